@@ sv/tcprx_pkg.sv @@
// tcprx_pkg: shared types and constants of the single-socket tcp receiver
// used by tcprx_seg_engine, tcprx_out_queue and tcp_single_socket_receiver_core
// no dependencies
`default_nettype none

package tcprx_pkg;

    // connection state, encoded as reported in the reply descriptor
    typedef enum logic [1:0] {
        ST_LISTEN = 2'd0,
        ST_SYN    = 2'd1,
        ST_EST    = 2'd2,
        ST_CLOSE  = 2'd3
    } conn_state_t;

    // word positions within a segment
    localparam logic [3:0] POS_LENGTH   = 4'd0;
    localparam logic [3:0] POS_IP_FROM  = 4'd1;
    localparam logic [3:0] POS_IP_TO    = 4'd2;
    localparam logic [3:0] POS_SRC_PORT = 4'd3;
    localparam logic [3:0] POS_DST_PORT = 4'd4;
    localparam logic [3:0] POS_SEQ_HI   = 4'd5;
    localparam logic [3:0] POS_SEQ_LO   = 4'd6;
    localparam logic [3:0] POS_ACK_HI   = 4'd7;
    localparam logic [3:0] POS_ACK_LO   = 4'd8;
    localparam logic [3:0] POS_FLAGS    = 4'd9;
    localparam logic [3:0] POS_WINDOW   = 4'd10;
    localparam logic [3:0] POS_CHECKSUM = 4'd11;
    localparam logic [3:0] POS_URGENT   = 4'd12;
    localparam logic [3:0] POS_OPTIONS  = 4'd13;
    localparam logic [3:0] POS_PAYLOAD  = 4'd14;

    // tcp flag bits
    localparam logic [5:0] F_FIN = 6'h01;
    localparam logic [5:0] F_SYN = 6'h02;
    localparam logic [5:0] F_RST = 6'h04;
    localparam logic [5:0] F_PSH = 6'h08;
    localparam logic [5:0] F_ACK = 6'h10;
    localparam logic [5:0] F_URG = 6'h20;

    // header sizes
    localparam logic [15:0] HDR_BYTES     = 16'd20;
    localparam logic [3:0]  HDR_MIN_WORDS = 4'd5;

    // configuration register indexes
    localparam logic CFG_LOCAL_PORT  = 1'b0;
    localparam logic CFG_MAX_TIMEOUT = 1'b1;

    // configuration reset values
    localparam logic [15:0] LOCAL_PORT_RST  = 16'd80;
    localparam logic [31:0] MAX_TIMEOUT_RST = 32'd1000000;

    // result kind carried on tuser
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // result queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // reply descriptor, packed so that it follows the two data bytes in tdata
    typedef struct packed {
        logic [5:0]  flags;
        logic [31:0] ack;
        logic [31:0] seq;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [15:0] ip_from;
        logic [15:0] ip_to;
        logic [1:0]  state;
    } reply_t;

    // everything one input beat produces
    typedef struct packed {
        logic        has_data;
        logic        has_reply;
        logic [15:0] word;
        reply_t      reply;
    } entry_t;

endpackage

`default_nettype wire

@@ sv/tcprx_seg_engine.sv @@
// tcprx_seg_engine: header decode, option skip and connection state machine
// updates all socket state on an accepted input beat and issues a queue entry for data or a reply
// depends on tcprx_pkg
`default_nettype none

module tcprx_seg_engine (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_accept,
    input  wire logic                in_tick,
    input  wire logic [15:0]         in_word,
    input  wire logic                cfg_accept,
    input  wire logic                cfg_index,
    input  wire logic [31:0]         cfg_data,
    output logic                     push,
    output tcprx_pkg::entry_t        push_entry
);

    tcprx_pkg::conn_state_t conn_reg, conn_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] seg_length_reg, seg_length_next;
    logic [15:0] ip_from_reg, ip_from_next;
    logic [15:0] ip_to_reg, ip_to_next;
    logic [15:0] remote_port_reg, remote_port_next;
    logic [15:0] dest_port_reg, dest_port_next;
    logic [31:0] seg_seq_reg, seg_seq_next;
    logic [31:0] seg_ack_reg, seg_ack_next;
    logic [3:0]  hdr_len_reg, hdr_len_next;
    logic [5:0]  seg_flags_reg, seg_flags_next;
    logic [4:0]  options_left_reg, options_left_next;
    logic [15:0] payload_left_reg, payload_left_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic        forward_reg, forward_next;
    logic        mismatch_reg, mismatch_next;
    logic [31:0] expected_reg, expected_next;
    logic [15:0] src_latch_reg, src_latch_next;
    logic [15:0] dst_latch_reg, dst_latch_next;
    logic [5:0]  rflags_reg, rflags_next;
    logic [31:0] timeout_reg, timeout_next;
    logic [15:0] local_port_reg;
    logic [31:0] max_timeout_reg;

    // size decode, evaluated while the window word passes
    logic [4:0]  opt_words;
    logic [5:0]  opt_bytes;
    logic [15:0] base_bytes;
    logic [15:0] pay_bytes;
    logic [16:0] pay_round;
    logic        do_advance;
    logic        do_data;
    logic        do_reply;

    always_comb begin
        opt_words  = (hdr_len_reg > tcprx_pkg::HDR_MIN_WORDS)
                   ? {hdr_len_reg - tcprx_pkg::HDR_MIN_WORDS, 1'b0} : 5'd0;
        opt_bytes  = {opt_words, 1'b0};
        base_bytes = (seg_length_reg > tcprx_pkg::HDR_BYTES)
                   ? seg_length_reg - tcprx_pkg::HDR_BYTES : 16'd0;
        pay_bytes  = (base_bytes > {10'd0, opt_bytes})
                   ? base_bytes - {10'd0, opt_bytes} : 16'd0;
        pay_round  = {1'b0, pay_bytes} + 17'd1;
    end

    // per-beat decode and state step
    always_comb begin
        conn_next         = conn_reg;
        pos_next          = pos_reg;
        seg_length_next   = seg_length_reg;
        ip_from_next      = ip_from_reg;
        ip_to_next        = ip_to_reg;
        remote_port_next  = remote_port_reg;
        dest_port_next    = dest_port_reg;
        seg_seq_next      = seg_seq_reg;
        seg_ack_next      = seg_ack_reg;
        hdr_len_next      = hdr_len_reg;
        seg_flags_next    = seg_flags_reg;
        options_left_next = options_left_reg;
        payload_left_next = payload_left_reg;
        byte_count_next   = byte_count_reg;
        forward_next      = forward_reg;
        mismatch_next     = mismatch_reg;
        expected_next     = expected_reg;
        src_latch_next    = src_latch_reg;
        dst_latch_next    = dst_latch_reg;
        rflags_next       = rflags_reg;
        timeout_next      = timeout_reg;
        do_advance        = 1'b0;
        do_data           = 1'b0;
        do_reply          = 1'b0;

        if (in_accept && in_tick) begin
            // idle tick only counts between segments
            if (pos_reg == tcprx_pkg::POS_LENGTH) begin
                timeout_next = timeout_reg - 32'd1;
                if (timeout_reg == 32'd0 && conn_reg != tcprx_pkg::ST_LISTEN) begin
                    conn_next   = tcprx_pkg::ST_LISTEN;
                    rflags_next = tcprx_pkg::F_RST | tcprx_pkg::F_ACK;
                end
            end
        end else if (in_accept) begin
            pos_next = pos_reg + 4'd1;
            case (pos_reg)
                tcprx_pkg::POS_LENGTH:   seg_length_next  = in_word;
                tcprx_pkg::POS_IP_FROM:  ip_from_next     = in_word;
                tcprx_pkg::POS_IP_TO:    ip_to_next       = in_word;
                tcprx_pkg::POS_SRC_PORT: remote_port_next = in_word;
                tcprx_pkg::POS_DST_PORT: dest_port_next   = in_word;
                tcprx_pkg::POS_SEQ_HI:   seg_seq_next     = {in_word, 16'd0};
                tcprx_pkg::POS_SEQ_LO:   seg_seq_next     = {seg_seq_reg[31:16], in_word};
                tcprx_pkg::POS_ACK_HI:   seg_ack_next     = {in_word, 16'd0};
                tcprx_pkg::POS_ACK_LO:   seg_ack_next     = {seg_ack_reg[31:16], in_word};
                tcprx_pkg::POS_FLAGS: begin
                    hdr_len_next   = in_word[15:12];
                    seg_flags_next = in_word[5:0];
                end
                tcprx_pkg::POS_WINDOW: begin
                    // sizes only depend on length and header length
                    options_left_next = opt_words;
                    byte_count_next   = pay_bytes;
                    payload_left_next = pay_round[16:1];
                end
                tcprx_pkg::POS_CHECKSUM: ;
                tcprx_pkg::POS_URGENT: begin
                    do_advance    = 1'b1;
                    forward_next  = 1'b0;
                    mismatch_next = (dest_port_reg != local_port_reg);
                    if (!mismatch_next) begin
                        case (conn_reg)
                            tcprx_pkg::ST_LISTEN: begin
                                rflags_next = 6'd0;
                                if ((seg_flags_reg & tcprx_pkg::F_SYN) != 6'd0) begin
                                    timeout_next   = max_timeout_reg;
                                    conn_next      = tcprx_pkg::ST_SYN;
                                    src_latch_next = local_port_reg;
                                    dst_latch_next = remote_port_reg;
                                    expected_next  = seg_seq_reg + 32'd1;
                                    rflags_next    = tcprx_pkg::F_SYN | tcprx_pkg::F_ACK;
                                end
                            end
                            tcprx_pkg::ST_SYN: begin
                                if ((seg_flags_reg & tcprx_pkg::F_ACK) != 6'd0) begin
                                    timeout_next = max_timeout_reg;
                                    conn_next    = tcprx_pkg::ST_EST;
                                    rflags_next  = rflags_reg & ~tcprx_pkg::F_SYN;
                                end
                            end
                            tcprx_pkg::ST_EST: begin
                                if ((seg_flags_reg & tcprx_pkg::F_FIN) != 6'd0) begin
                                    // fin moves the expected number past this seq
                                    timeout_next  = max_timeout_reg;
                                    conn_next     = tcprx_pkg::ST_CLOSE;
                                    rflags_next   = rflags_reg | tcprx_pkg::F_FIN;
                                    expected_next = seg_seq_reg + 32'd1;
                                end else if (seg_seq_reg == expected_reg) begin
                                    timeout_next  = max_timeout_reg;
                                    forward_next  = 1'b1;
                                    expected_next = seg_seq_reg + {16'd0, byte_count_reg};
                                end
                            end
                            default: begin
                                if ((seg_flags_reg & tcprx_pkg::F_ACK) != 6'd0) begin
                                    timeout_next = max_timeout_reg;
                                    conn_next    = tcprx_pkg::ST_LISTEN;
                                    rflags_next  = 6'd0;
                                end
                            end
                        endcase
                        if ((seg_flags_reg & tcprx_pkg::F_RST) != 6'd0) begin
                            timeout_next = max_timeout_reg;
                            conn_next    = tcprx_pkg::ST_LISTEN;
                            rflags_next  = 6'd0;
                        end
                    end
                end
                tcprx_pkg::POS_OPTIONS: begin
                    do_advance = 1'b1;
                    if (options_left_reg != 5'd0) begin
                        options_left_next = options_left_reg - 5'd1;
                    end
                end
                default: begin
                    // payload word
                    do_advance = 1'b1;
                    do_data    = forward_reg;
                    if (payload_left_reg != 16'd0) begin
                        payload_left_next = payload_left_reg - 16'd1;
                    end
                end
            endcase

            // move on to options, payload or the next segment
            if (do_advance) begin
                if (options_left_next != 5'd0) begin
                    pos_next = tcprx_pkg::POS_OPTIONS;
                end else if (payload_left_next != 16'd0) begin
                    pos_next = tcprx_pkg::POS_PAYLOAD;
                end else begin
                    pos_next = tcprx_pkg::POS_LENGTH;
                    do_reply = !mismatch_next;
                end
            end
        end
    end

    // queue entry for this beat
    always_comb begin
        push                      = do_data || do_reply;
        push_entry.has_data       = do_data;
        push_entry.has_reply      = do_reply;
        push_entry.word           = in_word;
        push_entry.reply.flags    = rflags_next;
        push_entry.reply.ack      = expected_next;
        push_entry.reply.seq      = seg_ack_next;
        push_entry.reply.dst_port = dst_latch_next;
        push_entry.reply.src_port = src_latch_next;
        push_entry.reply.ip_from  = ip_to_next;
        push_entry.reply.ip_to    = ip_from_next;
        push_entry.reply.state    = conn_next;
    end

    // socket state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conn_reg         <= tcprx_pkg::ST_LISTEN;
            pos_reg          <= tcprx_pkg::POS_LENGTH;
            seg_length_reg   <= 16'd0;
            ip_from_reg      <= 16'd0;
            ip_to_reg        <= 16'd0;
            remote_port_reg  <= 16'd0;
            dest_port_reg    <= 16'd0;
            seg_seq_reg      <= 32'd0;
            seg_ack_reg      <= 32'd0;
            hdr_len_reg      <= 4'd0;
            seg_flags_reg    <= 6'd0;
            options_left_reg <= 5'd0;
            payload_left_reg <= 16'd0;
            byte_count_reg   <= 16'd0;
            forward_reg      <= 1'b0;
            mismatch_reg     <= 1'b0;
            expected_reg     <= 32'd0;
            src_latch_reg    <= 16'd0;
            dst_latch_reg    <= 16'd0;
            rflags_reg       <= 6'd0;
            timeout_reg      <= 32'd0;
        end else begin
            conn_reg         <= conn_next;
            pos_reg          <= pos_next;
            seg_length_reg   <= seg_length_next;
            ip_from_reg      <= ip_from_next;
            ip_to_reg        <= ip_to_next;
            remote_port_reg  <= remote_port_next;
            dest_port_reg    <= dest_port_next;
            seg_seq_reg      <= seg_seq_next;
            seg_ack_reg      <= seg_ack_next;
            hdr_len_reg      <= hdr_len_next;
            seg_flags_reg    <= seg_flags_next;
            options_left_reg <= options_left_next;
            payload_left_reg <= payload_left_next;
            byte_count_reg   <= byte_count_next;
            forward_reg      <= forward_next;
            mismatch_reg     <= mismatch_next;
            expected_reg     <= expected_next;
            src_latch_reg    <= src_latch_next;
            dst_latch_reg    <= dst_latch_next;
            rflags_reg       <= rflags_next;
            timeout_reg      <= timeout_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_port_reg  <= tcprx_pkg::LOCAL_PORT_RST;
            max_timeout_reg <= tcprx_pkg::MAX_TIMEOUT_RST;
        end else if (cfg_accept) begin
            case (cfg_index)
                tcprx_pkg::CFG_LOCAL_PORT:  local_port_reg  <= cfg_data[15:0];
                tcprx_pkg::CFG_MAX_TIMEOUT: max_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/tcprx_out_queue.sv @@
// tcprx_out_queue: small result queue, at most one entry per input beat
// splits an entry into a data beat and/or a reply beat on the master side
// depends on tcprx_pkg
`default_nettype none

module tcprx_out_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  tcprx_pkg::entry_t        push_entry,
    output logic                     space,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [151:0]             m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);

    tcprx_pkg::entry_t entries [tcprx_pkg::QDEPTH];
    tcprx_pkg::entry_t head;
    logic [tcprx_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tcprx_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tcprx_pkg::QPTR_W:0]   count_reg, count_next;
    logic                         phase_reg, phase_next;
    logic                         data_beat;
    logic                         beat;
    logic                         pop;

    assign space = (count_reg != (tcprx_pkg::QPTR_W+1)'(tcprx_pkg::QDEPTH));
    assign head  = entries[rd_ptr_reg];

    // choose the beat shown from the head entry
    always_comb begin
        data_beat = head.has_data && !phase_reg;
        m_tvalid  = (count_reg != '0);
        if (data_beat) begin
            m_tuser = tcprx_pkg::KIND_DATA;
            m_tlast = !head.has_reply;
            m_tdata = {136'd0, head.word[7:0], head.word[15:8]};
        end else begin
            m_tuser = tcprx_pkg::KIND_REPLY;
            m_tlast = 1'b1;
            m_tdata = {head.reply, 16'd0};
        end
        beat = m_tvalid && m_tready;
        pop  = beat && m_tlast;
    end

    // pointers and beat phase
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{tcprx_pkg::QPTR_W{1'b0}}, push}
                    - {{tcprx_pkg::QPTR_W{1'b0}}, pop};
        if (pop) begin
            phase_next = 1'b0;
        end else if (beat) begin
            phase_next = 1'b1;
        end else begin
            phase_next = phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ sv/tcp_single_socket_receiver_core.sv @@
// tcp_single_socket_receiver_core: top level of the single-socket tcp receiver
// instantiates tcprx_seg_engine and tcprx_out_queue, depends on tcprx_pkg
//
// usage:
//   slave channel: one beat per segment word (s_tuser = 0, word on s_tdata) or
//   one idle tick (s_tuser = 1). a segment is length, source ip word, dest ip
//   word, the tcp header words, option words, then payload words.
//   master channel: one beat per result. m_tuser = 0 is a payload byte pair,
//   m_tuser = 1 a reply descriptor given at the end of each segment that
//   matched local_port. m_tlast marks the last beat caused by one input beat.
//   config channel: cfg_index 0 = local_port, 1 = max_timeout; always ready.
//   output: the results of an accepted beat are registered in the result queue, then shown.
//   throughput: one input beat per cycle while s_tready is high; every beat is
//   decoded in the cycle it is accepted, the four-entry result queue absorbs the
//   final payload word of a segment, which gives two master beats.
//   stall: when the master side holds off, the queue fills and s_tready drops
//   once four entries are waiting.
//   reset: aresetn low for one edge returns the socket to listen, clears the
//   queue and restores local_port 80 and max_timeout 1000000.
`default_nettype none

module tcp_single_socket_receiver_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // slave side
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [15:0] seg_word
    input  wire logic [0:0]   s_tuser,   // [0] func
    // master side
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata,   // [7:0] data_high, [15:8] data_low,
                                         // [17:16] reply_state, [33:18] reply_ip_to,
                                         // [49:34] reply_ip_from, [65:50] reply_src_port,
                                         // [81:66] reply_dst_port, [113:82] reply_seq,
                                         // [145:114] reply_ack, [151:146] reply_flags
    output logic [0:0]        m_tuser,   // [0] kind
    output logic              m_tlast,
    // configuration write
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data
);

    logic              space;
    logic              push;
    tcprx_pkg::entry_t push_entry;
    logic              in_accept;
    logic              cfg_accept;

    assign s_tready   = space;
    assign in_accept  = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // header decode and connection state
    tcprx_seg_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_tick    (s_tuser[0]),
        .in_word    (s_tdata),
        .cfg_accept (cfg_accept),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_entry (push_entry)
    );

    // result queue and beat split
    tcprx_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .space      (space),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser[0]),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

@@ test/tcprx_checker.sv @@
// tcprx_checker: predicts every master beat of tcp_single_socket_receiver_core
// from the beats seen on its slave and config channels, and compares them
// depends on tcprx_pkg
`default_nettype none

module tcprx_checker
    import tcprx_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [15:0]  s_tdata,   // [15:0] seg_word
    input  wire logic [0:0]   s_tuser,   // [0] func
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [151:0] m_tdata,   // [7:0] data_high ... [151:146] reply_flags
    input  wire logic [0:0]   m_tuser,   // [0] kind
    input  wire logic         m_tlast,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data,
    output int                mismatches,
    output int                results_due
);

    // slave beat kinds on s_tuser
    localparam logic FUNC_WORD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // one master beat as the block should give it
    typedef struct packed {
        logic        kind;
        logic        last;
        logic [7:0]  data_high;
        logic [7:0]  data_low;
        logic [1:0]  state;
        logic [15:0] ip_to;
        logic [15:0] ip_from;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [5:0]  flags;
    } rx_result_t;

    rx_result_t results_owed[$];

    // register copies
    logic [15:0] port_reg;
    logic [31:0] timeout_reg;

    // socket copy
    conn_state_t sock_state;
    logic [3:0]  word_pos;
    logic [15:0] seg_len;
    logic [15:0] src_ip;
    logic [15:0] dst_ip;
    logic [15:0] peer_port;
    logic [15:0] seen_port;
    logic [31:0] seg_seq_no;
    logic [31:0] seg_ack_no;
    logic [15:0] hdr_flags;
    logic [4:0]  opts_left;
    logic [15:0] words_left;
    logic [15:0] payload_bytes;
    logic        pass_payload;
    logic        foreign_port;
    logic [31:0] next_rx_seq;
    logic [15:0] latched_local;
    logic [15:0] latched_remote;
    logic [5:0]  answer_flags;
    logic [31:0] idle_timer;

    task automatic reset_copy();
        results_owed.delete();
        mismatches     = 0;
        port_reg       = LOCAL_PORT_RST;
        timeout_reg    = MAX_TIMEOUT_RST;
        sock_state     = ST_LISTEN;
        word_pos       = POS_LENGTH;
        seg_len        = '0;
        src_ip         = '0;
        dst_ip         = '0;
        peer_port      = '0;
        seen_port      = '0;
        seg_seq_no     = '0;
        seg_ack_no     = '0;
        hdr_flags      = '0;
        opts_left      = '0;
        words_left     = '0;
        payload_bytes  = '0;
        pass_payload   = 1'b0;
        foreign_port   = 1'b0;
        next_rx_seq    = '0;
        latched_local  = '0;
        latched_remote = '0;
        answer_flags   = '0;
        idle_timer     = '0;
    endtask

    // sizes, port check and connection step once the header is in
    task automatic judge_header();
        int hlen;
        int opt_words;
        int nbytes;
        logic [5:0] fl;
        hlen = int'(hdr_flags[15:12]);
        fl   = hdr_flags[5:0];
        opt_words = (hlen > int'(HDR_MIN_WORDS)) ? (hlen - int'(HDR_MIN_WORDS)) * 2 : 0;
        nbytes = (seg_len > HDR_BYTES) ? int'(seg_len) - int'(HDR_BYTES) : 0;
        nbytes = (nbytes > opt_words * 2) ? nbytes - opt_words * 2 : 0;
        opts_left     = 5'(opt_words);
        payload_bytes = 16'(nbytes);
        words_left    = 16'((nbytes + 1) >> 1);
        pass_payload  = 1'b0;
        foreign_port  = (seen_port != port_reg);
        if (foreign_port) return;

        case (sock_state)
            ST_LISTEN: begin
                answer_flags = '0;
                if ((fl & F_SYN) != 0) begin
                    idle_timer     = timeout_reg;
                    sock_state     = ST_SYN;
                    latched_local  = port_reg;
                    latched_remote = peer_port;
                    next_rx_seq    = seg_seq_no + 32'd1;
                    answer_flags   = F_SYN | F_ACK;
                end
            end
            ST_SYN: begin
                if ((fl & F_ACK) != 0) begin
                    idle_timer   = timeout_reg;
                    sock_state   = ST_EST;
                    answer_flags = answer_flags & ~F_SYN;
                end
            end
            ST_EST: begin
                if ((fl & F_FIN) != 0) begin
                    idle_timer   = timeout_reg;
                    sock_state   = ST_CLOSE;
                    answer_flags = answer_flags | F_FIN;
                    next_rx_seq  = seg_seq_no + 32'd1;
                end
                // in-order check sees the sequence a fin just moved
                if (seg_seq_no == next_rx_seq) begin
                    idle_timer   = timeout_reg;
                    pass_payload = 1'b1;
                    next_rx_seq  = seg_seq_no + {16'h0, payload_bytes};
                end
            end
            default: begin
                if ((fl & F_ACK) != 0) begin
                    idle_timer   = timeout_reg;
                    sock_state   = ST_LISTEN;
                    answer_flags = '0;
                end
            end
        endcase
        if ((fl & F_RST) != 0) begin
            idle_timer   = timeout_reg;
            sock_state   = ST_LISTEN;
            answer_flags = '0;
        end
    endtask

    task automatic take_tick();
        logic expired;
        // ticks inside a segment are ignored
        if (word_pos == POS_LENGTH) begin
            expired    = (idle_timer == '0);
            idle_timer = idle_timer - 32'd1;
            if (expired && sock_state != ST_LISTEN) begin
                sock_state   = ST_LISTEN;
                answer_flags = F_RST | F_ACK;
            end
        end
    endtask

    task automatic take_word(input logic [15:0] w);
        logic       close_out;
        logic       emit_data;
        logic       emit_reply;
        rx_result_t beat;
        close_out  = 1'b0;
        emit_data  = 1'b0;
        emit_reply = 1'b0;
        case (word_pos)
            POS_LENGTH:   seg_len = w;
            POS_IP_FROM:  src_ip = w;
            POS_IP_TO:    dst_ip = w;
            POS_SRC_PORT: peer_port = w;
            POS_DST_PORT: seen_port = w;
            POS_SEQ_HI:   seg_seq_no = {w, 16'h0};
            POS_SEQ_LO:   seg_seq_no[15:0] = w;
            POS_ACK_HI:   seg_ack_no = {w, 16'h0};
            POS_ACK_LO:   seg_ack_no[15:0] = w;
            POS_FLAGS:    hdr_flags = w;
            POS_WINDOW, POS_CHECKSUM: ;
            POS_URGENT: begin
                judge_header();
                close_out = 1'b1;
            end
            POS_OPTIONS: begin
                if (opts_left != '0) opts_left = opts_left - 5'd1;
                close_out = 1'b1;
            end
            default: begin
                emit_data = pass_payload;
                if (words_left != '0) words_left = words_left - 16'd1;
                close_out = 1'b1;
            end
        endcase

        if (!close_out) begin
            word_pos = word_pos + 4'd1;
        end else begin
            if (opts_left != '0) begin
                word_pos = POS_OPTIONS;
            end else if (words_left != '0) begin
                word_pos = POS_PAYLOAD;
            end else begin
                word_pos   = POS_LENGTH;
                emit_reply = !foreign_port;
            end
            if (emit_data) begin
                beat           = '0;
                beat.kind      = KIND_DATA;
                beat.last      = !emit_reply;
                beat.data_high = w[15:8];
                beat.data_low  = w[7:0];
                results_owed.push_back(beat);
            end
            if (emit_reply) begin
                beat          = '0;
                beat.kind     = KIND_REPLY;
                beat.last     = 1'b1;
                beat.state    = sock_state;
                beat.ip_to    = src_ip;
                beat.ip_from  = dst_ip;
                beat.src_port = latched_local;
                beat.dst_port = latched_remote;
                beat.seq      = seg_ack_no;
                beat.ack      = next_rx_seq;
                beat.flags    = answer_flags;
                results_owed.push_back(beat);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_beat();
        rx_result_t want;
        if (results_owed.size() == 0) begin
            $error("result beat with nothing expected: kind %0d tdata 0x%0h",
                   m_tuser[0], m_tdata);
            mismatches++;
            return;
        end
        want = results_owed.pop_front();
        check_field("kind", want.kind, m_tuser[0]);
        check_field("last", want.last, m_tlast);
        check_field("data_high", want.data_high, m_tdata[7:0]);
        check_field("data_low", want.data_low, m_tdata[15:8]);
        check_field("reply_state", want.state, m_tdata[17:16]);
        check_field("reply_ip_to", want.ip_to, m_tdata[33:18]);
        check_field("reply_ip_from", want.ip_from, m_tdata[49:34]);
        check_field("reply_src_port", want.src_port, m_tdata[65:50]);
        check_field("reply_dst_port", want.dst_port, m_tdata[81:66]);
        check_field("reply_seq", want.seq, m_tdata[113:82]);
        check_field("reply_ack", want.ack, m_tdata[145:114]);
        check_field("reply_flags", want.flags, m_tdata[151:146]);
    endtask

    // results first: a beat accepted now cannot cause a result at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_copy();
        end else begin
            if (m_tvalid && m_tready) check_beat();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LOCAL_PORT:  port_reg = cfg_data[15:0];
                    CFG_MAX_TIMEOUT: timeout_reg = cfg_data;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser[0])
                    FUNC_TICK: take_tick();
                    FUNC_WORD: take_word(s_tdata);
                endcase
            end
        end
        results_due = results_owed.size();
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// testbench: stimulus and verdict for tcp_single_socket_receiver_core
// drives segments, ticks and register writes; tcprx_checker does the checking
// depends on tcprx_pkg, tcp_single_socket_receiver_core and tcprx_checker
`default_nettype none

module testbench;
    import tcprx_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int LONG_HOLD    = 300;
    localparam logic FUNC_WORD  = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    int mismatches;
    int results_due;
    int cycle_count = 0;
    int beats_sent  = 0;
    int gap_odds    = 4;
    bit calm        = 1'b0;  // closing part without idling
    bit hold_req    = 1'b0;  // asks the receiver for one long hold-off
    logic [15:0] cur_port    = LOCAL_PORT_RST;
    logic [31:0] cur_timeout = MAX_TIMEOUT_RST;
    logic [31:0] peer_seq;   // next in-order sequence number of the remote end

    tcp_single_socket_receiver_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tcprx_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tcp_single_socket_receiver_core regression: fail");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off, none when calm
    initial begin : rx_ready
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    function automatic logic [15:0] rand_word();
        return 16'($urandom);
    endfunction

    // one slave beat, after an optional idle burst
    task automatic send_beat(input logic func, input logic [15:0] w);
        if (!calm && $urandom_range(0, gap_odds) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(FUNC_TICK, rand_word());
    endtask

    // a whole segment; a broken one turns to zeros after a random cut
    task automatic send_segment(input logic [15:0] dst, input logic [5:0] flags,
                                input logic [31:0] seq, input logic [31:0] ack,
                                input logic [3:0] hlen, input logic [15:0] len,
                                input bit broken);
        logic [15:0] words[$];
        int opt_words;
        int nbytes;
        int cut;
        int i;
        opt_words = (hlen > HDR_MIN_WORDS) ? (int'(hlen) - int'(HDR_MIN_WORDS)) * 2 : 0;
        nbytes = (len > HDR_BYTES) ? int'(len) - int'(HDR_BYTES) : 0;
        nbytes = (nbytes > opt_words * 2) ? nbytes - opt_words * 2 : 0;
        words.push_back(len);
        words.push_back(rand_word());
        words.push_back(rand_word());
        words.push_back(rand_word());
        words.push_back(dst);
        words.push_back(seq[31:16]);
        words.push_back(seq[15:0]);
        words.push_back(ack[31:16]);
        words.push_back(ack[15:0]);
        words.push_back({hlen, 6'($urandom), flags});
        repeat (3) words.push_back(rand_word());
        repeat (opt_words) words.push_back(rand_word());
        repeat ((nbytes + 1) / 2) words.push_back(rand_word());
        cut = broken ? $urandom_range(1, words.size() - 1) : words.size();
        for (i = 0; i < words.size(); i++) begin
            // a tick inside a segment must be ignored
            if (i > 0 && $urandom_range(0, 39) == 0) send_beat(FUNC_TICK, rand_word());
            send_beat(FUNC_WORD, (i < cut) ? words[i] : 16'h0);
        end
    endtask

    // in-order data segment that moves the remote sequence on
    task automatic send_data(input int nbytes, input logic [5:0] flags);
        send_segment(cur_port, flags, peer_seq, $urandom, 4'd5, 16'(20 + nbytes), 1'b0);
        peer_seq = peer_seq + 32'(nbytes);
    endtask

    // open, exchange, and mostly close one connection
    task automatic run_session();
        int ndata;
        int nbytes;
        int hl_i;
        bit in_order;
        logic [31:0] seq;
        case ($urandom_range(0, 2))
            0: gap_odds = 2;
            1: gap_odds = 8;
            default: gap_odds = 1000;
        endcase
        peer_seq = $urandom;

        // wrong port noise
        if ($urandom_range(0, 3) == 0)
            send_segment(cur_port ^ 16'($urandom_range(1, 65535)), 6'($urandom), $urandom,
                         $urandom, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 60)),
                         1'b0);

        // handshake
        send_segment(cur_port, F_SYN | (6'($urandom) & (F_PSH | F_URG)), peer_seq,
                     $urandom, 4'd5, 16'd20, $urandom_range(0, 9) == 0);
        peer_seq = peer_seq + 32'd1;
        if ($urandom_range(0, 3) == 0) send_ticks($urandom_range(1, 3));
        send_segment(cur_port, F_ACK, peer_seq, $urandom, 4'd5, 16'd20, 1'b0);

        // data
        ndata = $urandom_range(1, 6);
        repeat (ndata) begin
            if ($urandom_range(0, 7) == 0) begin
                // odd sizes: short length, short header, options past the payload
                seq = ($urandom_range(0, 1) == 0) ? peer_seq : $urandom;
                send_segment(cur_port, 6'($urandom), seq, $urandom,
                             4'($urandom_range(0, 15)), 16'($urandom_range(0, 90)),
                             $urandom_range(0, 5) == 0);
            end else begin
                nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
                                                    : $urandom_range(0, 16);
                hl_i = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 8) : 5;
                in_order = ($urandom_range(0, 4) != 0);
                seq = in_order ? peer_seq : $urandom;
                send_segment(cur_port, F_ACK | (6'($urandom) & (F_PSH | F_URG)), seq,
                             $urandom, 4'(hl_i), 16'(20 + 4 * (hl_i - 5) + nbytes),
                             $urandom_range(0, 9) == 0);
                if (in_order) peer_seq = peer_seq + 32'(nbytes);
            end
            if ($urandom_range(0, 5) == 0) send_ticks($urandom_range(1, 3));
        end

        // closing
        case ($urandom_range(0, 4))
            0: begin
                send_data($urandom_range(0, 6), F_FIN | F_ACK);
                send_segment(cur_port, F_ACK, peer_seq, $urandom, 4'd5, 16'd20, 1'b0);
            end
            1: send_data($urandom_range(0, 9), F_RST | F_ACK);
            2: send_ticks((cur_timeout <= 32'd20) ? int'(cur_timeout) + 2 : 3);
            default: ;
        endcase
    endtask

    // wait until every expected result is out and the block has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [15:0] port, input logic [31:0] tmo);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LOCAL_PORT;
        cfg_data  <= {16'h0, port};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_MAX_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_port    = port;
        cur_timeout = tmo;
    endtask

    task automatic run_until(input int mark);
        while (beats_sent < mark) run_session();
    endtask

    // stimulus and verdict
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= FUNC_WORD;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_LOCAL_PORT;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: tick from a zero counter, syn with short length and
        // short header and all-ones sequence, options longer than payload,
        // then an odd payload in order
        gap_odds = 6;
        send_ticks(1);
        send_segment(LOCAL_PORT_RST, F_SYN, 32'hffff_ffff, 32'hffff_ffff, 4'd4, 16'd19,
                     1'b0);
        send_segment(LOCAL_PORT_RST, F_ACK, 32'h0, 32'h0, 4'd6, 16'd23, 1'b0);
        peer_seq = 32'h0;
        send_data(3, F_ACK | F_PSH);
        run_until(230);

        // lowest port, timeout zero
        drain();
        set_regs(16'h0000, 32'h0000_0000);
        run_until(420);

        // highest port and timeout; long receiver hold-off under a big transfer
        drain();
        set_regs(16'hffff, 32'hffff_ffff);
        gap_odds = 1000;
        hold_req = 1'b1;
        peer_seq = $urandom;
        send_segment(cur_port, F_SYN, peer_seq, $urandom, 4'd5, 16'd20, 1'b0);
        peer_seq = peer_seq + 32'd1;
        send_segment(cur_port, F_ACK, peer_seq, $urandom, 4'd5, 16'd20, 1'b0);
        send_data(200, F_ACK);
        run_until(620);

        // short timeout so ticks drop connections
        drain();
        set_regs(rand_word(), 32'd3);
        run_until(810);

        // closing part without idling
        drain();
        set_regs(rand_word(), 32'($urandom_range(1, 12)));
        calm = 1'b1;
        run_until(1000);

        drain();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && results_due == 0)
            $display("tcp_single_socket_receiver_core regression: pass");
        else
            $display("tcp_single_socket_receiver_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
